// ----- rtl/sprite_frame_animator_defines.svh -----
// Assertion macros for the sprite frame animator.
// Used by the RTL modules; no other dependencies.
`ifndef SPRITE_FRAME_ANIMATOR_DEFINES_SVH
`define SPRITE_FRAME_ANIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SFA_ASSERT(lbl, prop, msg)
`define SFA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/sfa_pkg.sv -----
// Shared widths and register index codes for the sprite frame animator.
// No dependencies.
package sfa_pkg;

  localparam int FRAME_BITS    = 8;
  localparam int TIME_BITS     = 24;
  localparam int TILE_BITS     = 12;
  localparam int RECT_BITS     = 20;
  localparam int CNT_BITS      = $clog2(FRAME_BITS);
  localparam int ALU_BITS      = TIME_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [TIME_BITS-1:0] DELAY_RESET = TIME_BITS'(1000000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_FRAME = 3'd0,
    CFG_END_FRAME   = 3'd1,
    CFG_FRAME_DELAY = 3'd2,
    CFG_LOOP_ENABLE = 3'd3,
    CFG_COLUMNS     = 3'd4,
    CFG_TILE_WIDTH  = 3'd5,
    CFG_TILE_HEIGHT = 3'd6
  } cfg_idx_e;

endpackage

// ----- rtl/sprite_frame_animator.sv -----
// Sprite-sheet frame animator: frame timer, frame stepping and source rectangle.
// Depends on sfa_pkg and sprite_frame_animator_defines.svh.
//
// Usage:
//  - Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes the
//    range, frame delay, loop flag, column count and tile size. Always ready;
//    write only while no item is in flight. Unknown indexes are dropped.
//  - Input channel takes a tick item (mode 0, elapsed time) or a set item
//    (mode 1, new frame). Output channel returns one item per input item:
//    current frame, rectangle edges and the done flag.
//  - One shared 25-bit add/subtract unit does the timer, divide, multiply and
//    edge arithmetic under a small sequencer: accumulate and delay compare
//    (ticks with end above start only), restoring divide by columns, shift-add
//    multiplies (left, top), edge adds (right, bottom). An item is not
//    taken before the last one is through and the sequencer is back in idle.
//  - The input side is ready only while the sequencer is idle. A finished
//    result sits in the output register; a new item may be accepted meanwhile,
//    but its result waits in the last step until the output is taken.
//  - Reset clears frame, timer and done flag and loads the default registers.
module sprite_frame_animator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sfa_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [sfa_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic [sfa_pkg::TIME_BITS-1:0]        elapsed_time_i,
  input  logic [sfa_pkg::FRAME_BITS-1:0]       new_frame_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sfa_pkg::FRAME_BITS-1:0]       frame_index_o,
  output logic [sfa_pkg::RECT_BITS-1:0]        rect_left_o,
  output logic [sfa_pkg::RECT_BITS-1:0]        rect_top_o,
  output logic [sfa_pkg::RECT_BITS-1:0]        rect_right_o,
  output logic [sfa_pkg::RECT_BITS-1:0]        rect_bottom_o,
  output logic                                 anim_done_o
);
  import sfa_pkg::*;
  `include "sprite_frame_animator_defines.svh"

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TIME  = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_MULL  = 9'b000010000,
    S_MULT  = 9'b000100000,
    S_RIGHT = 9'b001000000,
    S_BOT   = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  // configuration
  logic [FRAME_BITS-1:0] start_q, end_q, cols_q;
  logic [TIME_BITS-1:0]  delay_q;
  logic                  loop_q;
  logic [TILE_BITS-1:0]  tw_q, th_q;

  // animation state
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [TIME_BITS-1:0]  accum_q, accum_d;
  logic                  done_q, done_d;

  // sequencer and working registers
  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  mode_q;
  logic [TIME_BITS-1:0]  dt_q;
  logic [FRAME_BITS-1:0] nf_q;
  logic [FRAME_BITS-1:0] quo_q, quo_d;
  logic [FRAME_BITS-1:0] rem_q, rem_d;
  logic [RECT_BITS-1:0]  left_q, left_d, top_q, top_d, right_q, right_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0] o_frame_q;
  logic [RECT_BITS-1:0]  o_left_q, o_top_q, o_right_q, o_bottom_q;
  logic                  o_done_q;
  logic                  out_load;

  // shared add/subtract unit
  logic [ALU_BITS-1:0]   alu_a, alu_b;
  logic                  alu_sub;
  logic [ALU_BITS:0]     alu_res;

  logic [FRAME_BITS-1:0] cols_eff;
  logic [FRAME_BITS:0]   rem_shift;
  logic [FRAME_BITS:0]   frame_inc;
  logic [FRAME_BITS-1:0] frame_adv;
  logic                  adv_done;
  logic                  mul_bit;
  logic                  in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (ALU_BITS+1)'(alu_sub);

  assign cols_eff  = (cols_q == '0) ? FRAME_BITS'(1) : cols_q;
  assign rem_shift = {rem_q, quo_q[FRAME_BITS-1]};

  // next frame on an advance; an increment off either end wraps or holds
  always_comb begin
    frame_inc = {1'b0, frame_q} + (FRAME_BITS+1)'(1);
    adv_done  = 1'b0;
    frame_adv = frame_inc[FRAME_BITS-1:0];
    if (frame_inc < {1'b0, start_q} || frame_inc > {1'b0, end_q}) begin
      if (loop_q) begin
        frame_adv = start_q;
      end else begin
        frame_adv = end_q;
        adv_done  = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    frame_d     = frame_q;
    accum_d     = accum_q;
    done_d      = done_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    left_d      = left_q;
    top_d       = top_q;
    right_d     = right_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    mul_bit     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_TIME;
        end
      end
      S_TIME: begin
        cnt_d = '0;
        rem_d = '0;
        if (mode_q) begin
          frame_d = nf_q;
          done_d  = 1'b0;
          quo_d   = nf_q;
          state_d = S_DIV;
        end else if (end_q <= start_q) begin
          quo_d   = frame_q;
          state_d = S_DIV;
        end else begin
          alu_a   = ALU_BITS'(accum_q);
          alu_b   = ALU_BITS'(dt_q);
          accum_d = alu_res[TIME_BITS] ? '1 : alu_res[TIME_BITS-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // carry out set means accum >= delay; strictly greater also needs nonzero
        alu_a   = ALU_BITS'(accum_q);
        alu_b   = ALU_BITS'(delay_q);
        alu_sub = 1'b1;
        quo_d   = frame_q;
        if (alu_res[ALU_BITS] && (alu_res[ALU_BITS-1:0] != '0)) begin
          accum_d = alu_res[TIME_BITS-1:0];
          frame_d = frame_adv;
          quo_d   = frame_adv;
          if (adv_done) begin
            done_d = 1'b1;
          end
        end
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        alu_a   = ALU_BITS'(rem_shift);
        alu_b   = ALU_BITS'(cols_eff);
        alu_sub = 1'b1;
        rem_d   = alu_res[ALU_BITS] ? alu_res[FRAME_BITS-1:0] : rem_shift[FRAME_BITS-1:0];
        quo_d   = {quo_q[FRAME_BITS-2:0], alu_res[ALU_BITS]};
        cnt_d   = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(FRAME_BITS - 1)) begin
          cnt_d   = '0;
          left_d  = '0;
          state_d = S_MULL;
        end
      end
      S_MULL: begin
        // left = remainder * tile width, MSB first
        mul_bit = rem_q[~cnt_q];
        alu_a   = ALU_BITS'({left_q[RECT_BITS-2:0], 1'b0});
        alu_b   = mul_bit ? ALU_BITS'(tw_q) : '0;
        left_d  = alu_res[RECT_BITS-1:0];
        cnt_d   = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(FRAME_BITS - 1)) begin
          cnt_d   = '0;
          top_d   = '0;
          state_d = S_MULT;
        end
      end
      S_MULT: begin
        mul_bit = quo_q[~cnt_q];
        alu_a   = ALU_BITS'({top_q[RECT_BITS-2:0], 1'b0});
        alu_b   = mul_bit ? ALU_BITS'(th_q) : '0;
        top_d   = alu_res[RECT_BITS-1:0];
        cnt_d   = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(FRAME_BITS - 1)) begin
          cnt_d   = '0;
          state_d = S_RIGHT;
        end
      end
      S_RIGHT: begin
        alu_a   = ALU_BITS'(left_q);
        alu_b   = ALU_BITS'(tw_q);
        right_d = alu_res[RECT_BITS-1:0];
        state_d = S_BOT;
      end
      S_BOT: begin
        alu_a = ALU_BITS'(top_q);
        alu_b = ALU_BITS'(th_q);
        // hold here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      frame_q     <= '0;
      accum_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      start_q     <= '0;
      end_q       <= '0;
      delay_q     <= DELAY_RESET;
      loop_q      <= 1'b1;
      cols_q      <= FRAME_BITS'(1);
      tw_q        <= TILE_BITS'(2);
      th_q        <= TILE_BITS'(2);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      frame_q     <= frame_d;
      accum_q     <= accum_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_FRAME: start_q <= cfg_data_i[FRAME_BITS-1:0];
          CFG_END_FRAME:   end_q   <= cfg_data_i[FRAME_BITS-1:0];
          CFG_FRAME_DELAY: delay_q <= cfg_data_i[TIME_BITS-1:0];
          CFG_LOOP_ENABLE: loop_q  <= cfg_data_i[0];
          CFG_COLUMNS:     cols_q  <= cfg_data_i[FRAME_BITS-1:0];
          CFG_TILE_WIDTH:  tw_q    <= cfg_data_i[TILE_BITS-1:0];
          CFG_TILE_HEIGHT: th_q    <= cfg_data_i[TILE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      dt_q   <= elapsed_time_i;
      nf_q   <= new_frame_i;
    end
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    left_q  <= left_d;
    top_q   <= top_d;
    right_q <= right_d;
    if (out_load) begin
      o_frame_q  <= frame_q;
      o_left_q   <= left_q;
      o_top_q    <= top_q;
      o_right_q  <= right_q;
      o_bottom_q <= alu_res[RECT_BITS-1:0];
      o_done_q   <= done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = o_frame_q;
  assign rect_left_o   = o_left_q;
  assign rect_top_o    = o_top_q;
  assign rect_right_o  = o_right_q;
  assign rect_bottom_o = o_bottom_q;
  assign anim_done_o   = o_done_q;

  `SFA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o,
              "input still ready after an item was accepted")
  `SFA_ASSERT(a_rem_below_cols, (state_q == S_MULL) |-> (rem_q < cols_eff),
              "division remainder not below column count")
  `SFA_ASSERT(a_out_from_last_step, $rose(out_valid_q) |-> $past(state_q == S_BOT),
              "result raised outside the final step")
  `SFA_ASSERT(a_mul_starts_clean,
              ((state_q == S_MULL) && $past(state_q == S_DIV)) |-> (cnt_q == '0 && left_q == '0),
              "multiply entered with stale counter or product")

endmodule
